### rtl/core/stlb_pkg.sv
`timescale 1ns / 1ps

package stlb_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// Fixed field widths
	localparam int INDEX_W = 12;
	localparam int KEY_W   = 64;
	localparam int POS_W   = 13;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Classified request passed from front to back
	typedef struct packed {
		logic              is_query;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  data;
	} req_t;

	// Walk engine status seen by the top level
	typedef struct packed {
		logic              walking;
		logic              finishing;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
	} status_t;

endpackage

### rtl/core/stlb_ram.sv
`timescale 1ns / 1ps

module stlb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read share the port; read data is registered and held when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/core/stlb_front.sv
`timescale 1ns / 1ps

module stlb_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            operation,
	input  logic [stlb_pkg::INDEX_W-1:0]    entry_index,
	input  logic [stlb_pkg::KEY_W-1:0]      entry_value,
	input  logic [stlb_pkg::KEY_W-1:0]      search_key,
	output logic                            req_valid,
	input  logic                            req_deq,
	output stlb_pkg::req_t                  req
);

	import stlb_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic accept;
	logic in_range;
	logic keep;
	req_t incoming;

	assign full      = (count_q == 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign req       = slot_q[rd_ptr_q];
	assign accept    = push && !full;

	// Classify: a load outside the table is taken and dropped
	assign in_range = (32'(entry_index) < 32'(TABLE_DEPTH));
	assign keep     = (operation == OP_QUERY) || in_range;

	always_comb begin
		incoming.is_query = (operation == OP_QUERY);
		incoming.addr     = ADDR_W'(entry_index);
		incoming.data     = (operation == OP_QUERY) ? search_key : entry_value;
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_deq) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept && keep, req_deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/core/stlb_back.sv
`timescale 1ns / 1ps

module stlb_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_deq,
	input  stlb_pkg::req_t                  req,
	output logic                            empty,
	input  logic                            pop,
	output logic [stlb_pkg::POS_W-1:0]      position,
	output stlb_pkg::status_t               status
);

	import stlb_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] hi_q;
	logic [ADDR_W-1:0] mid_q;
	logic [KEY_W-1:0]  key_q;
	logic              res_valid_q;
	logic [POS_W-1:0]  res_q;

	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [KEY_W-1:0]  ram_rdata;

	logic              slot_free;
	logic              finish;
	logic [POS_W-1:0]  fin_pos;
	logic              key_le;
	logic [ADDR_W-1:0] nlo;
	logic [ADDR_W-1:0] nhi;
	logic [ADDR_W-1:0] nmid;
	logic [ADDR_W-1:0] mid0;

	stlb_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (req.data),
		.rdata (ram_rdata)
	);

	assign slot_free = !res_valid_q || pop;
	assign key_le    = (key_q <= ram_rdata);
	assign nlo       = key_le ? lo_q : ADDR_W'(mid_q + 1'b1);
	assign nhi       = key_le ? mid_q : hi_q;
	assign nmid      = ADDR_W'(((ADDR_W+1)'(nlo) + (ADDR_W+1)'(nhi)) >> 1);
	assign mid0      = ADDR_W'(((ADDR_W+1)'(lo_q) + (ADDR_W+1)'(hi_q)) >> 1);

	always_comb begin
		req_deq  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = mid_q;
		finish   = 1'b0;
		fin_pos  = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_deq = 1'b1;
					if (req.is_query) begin
						ram_re   = 1'b1;
						ram_addr = LAST_ADDR;
					end else begin
						ram_we   = 1'b1;
						ram_addr = req.addr;
					end
				end
			end
			ST_CHECK: begin
				if (!key_le) begin
					finish  = 1'b1;
					fin_pos = POS_W'(TABLE_DEPTH);
				end else begin
					ram_re   = 1'b1;
					ram_addr = mid0;
				end
			end
			ST_WALK: begin
				if (nlo == nhi) begin
					finish  = 1'b1;
					fin_pos = POS_W'(nlo);
				end else begin
					ram_re   = 1'b1;
					ram_addr = nmid;
				end
			end
			default: begin
				ram_addr = mid_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid && req.is_query) begin
			key_q <= req.data;
		end
		if (finish && slot_free) begin
			res_q <= fin_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lo_q        <= '0;
			hi_q        <= LAST_ADDR;
			mid_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (finish && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req.is_query) begin
						lo_q    <= '0;
						hi_q    <= LAST_ADDR;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (finish) begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						mid_q   <= mid0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						if (slot_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						lo_q  <= nlo;
						hi_q  <= nhi;
						mid_q <= nmid;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty    = !res_valid_q;
	assign position = res_q;

	always_comb begin
		status.walking   = (state_q == ST_WALK);
		status.finishing = finish && slot_free;
		status.lo        = lo_q;
		status.hi        = hi_q;
	end

endmodule

### rtl/core/sorted_table_lower_bound.sv
`timescale 1ns / 1ps

// Channel    Handshake          Payload                                          Moves
// input      push / full        operation, entry_index, entry_value, search_key  load or query
// result     empty / pop        position                                         one per query
//
// A load request is written into the table as it is dequeued; a query dequeues and reads
// the last entry, checks it, then makes one table read per halving step, all on the single
// port of the key table.
// A two-entry request queue lets the input take requests while a walk runs.
// Reset clears the queue, the walk engine and the result slot; the table holds anything.
// A result waiting on pop holds the walk at its last step; the input stays open until
// the two-entry request queue fills.

module sorted_table_lower_bound (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         operation,
	input  logic [stlb_pkg::INDEX_W-1:0] entry_index,
	input  logic [stlb_pkg::KEY_W-1:0]   entry_value,
	input  logic [stlb_pkg::KEY_W-1:0]   search_key,
	output logic                         empty,
	input  logic                         pop,
	output logic [stlb_pkg::POS_W-1:0]   position
);

	import stlb_pkg::*;

	logic    req_valid;
	logic    req_deq;
	req_t    req;
	status_t status;

	// Front: take requests, drop loads outside the table, queue the rest
	stlb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.req_valid   (req_valid),
		.req_deq     (req_deq),
		.req         (req)
	);

	// Back: write loads into the table, run the halving walk for queries
	stlb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_deq   (req_deq),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.position  (position),
		.status    (status)
	);

	// The search interval never inverts during the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		status.walking |-> (status.lo < status.hi))
		else $error("walk interval inverted");

	// A shown position never exceeds the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(position) <= 32'(TABLE_DEPTH)))
		else $error("position beyond table depth");

	// A popped result with no new one finishing leaves the slot empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !status.finishing) |=> empty)
		else $error("result slot not released after pop");

endmodule

### dv/tb_sorted_table_lower_bound.sv
`timescale 1ns / 1ps

// Lower-bound search over a 4096-entry key table.
// Fill the whole table first, so that no walk ever touches an entry that was never written,
// then run a short table of directed requests and a long stretch of random ones.
module tb_sorted_table_lower_bound;
	import stlb_pkg::*;

	localparam int RESET_CYCLES    = 8;
	localparam int RANDOM_REQUESTS = 800;
	localparam int HOLD_AFTER      = 40;     // results seen before the long hold-off
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 32;     // margin for a stray result to show after the last owed one
	localparam int WATCHDOG_LIMIT  = 4000;   // hold-off + longest gap + one walk, several times
	localparam int REPORT_LINES    = 40;

	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [POS_W-1:0] POS_NONE = POS_W'(TABLE_DEPTH);

	// One directed request; known marks a row whose position is typed in by hand
	typedef struct packed {
		logic               operation;
		logic [INDEX_W-1:0] idx;
		logic [KEY_W-1:0]   value;
		logic [KEY_W-1:0]   key;
		logic               known;
		logic [POS_W-1:0]   pos;
	} stim_row_t;

	// The fill leaves entry i as {i, random low bits}, with the last entry below all ones,
	// so the typed positions hold whatever the low bits turn out to be.
	localparam int DIRECTED_ROWS = 19;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// smallest and largest keys
		'{OP_QUERY, 12'd0,   64'd0,   64'd0,                 1'b1, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   KEY_MAX,               1'b1, POS_NONE},
		// keys just at the start of an entry's range
		'{OP_QUERY, 12'd0,   64'd0,   {12'd1, 52'd0},        1'b1, 13'd1},
		'{OP_QUERY, 12'd0,   64'd0,   {12'h800, 52'd0},      1'b1, 13'd2048},
		'{OP_QUERY, 12'd0,   64'd0,   {12'hFFF, 52'd0},      1'b1, 13'd4095},
		// smallest value in the first entry
		'{OP_LOAD,  12'd0,   64'd0,   64'd0,                 1'b0, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   64'd0,                 1'b1, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   64'd1,                 1'b1, 13'd1},
		// largest value in the last entry: all ones is no longer beyond the table
		'{OP_LOAD,  12'hFFF, KEY_MAX, 64'd0,                 1'b0, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   KEY_MAX,               1'b1, 13'd4095},
		// a run of equal keys: the first of the run wins, one above skips the run
		'{OP_LOAD,  12'd100, {12'd100, 52'd0}, 64'd0,        1'b0, 13'd0},
		'{OP_LOAD,  12'd101, {12'd100, 52'd0}, 64'd0,        1'b0, 13'd0},
		'{OP_LOAD,  12'd102, {12'd100, 52'd0}, 64'd0,        1'b0, 13'd0},
		'{OP_LOAD,  12'd103, {12'd100, 52'd0}, 64'd0,        1'b0, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   {12'd100, 52'd0},      1'b1, 13'd100},
		'{OP_QUERY, 12'd0,   64'd0,   {12'd100, 52'd1},      1'b1, 13'd104},
		// break the order at the first midpoint; the walk result need not be a true lower bound
		'{OP_LOAD,  12'h7FF, 64'd0,   64'd0,                 1'b0, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   {12'h7FF, 52'd0},      1'b0, 13'd0},
		'{OP_QUERY, 12'd0,   64'd0,   {12'h400, 52'd5},      1'b0, 13'd0}
	};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               push        = 1'b0;
	logic               full;
	logic               operation   = OP_LOAD;
	logic [INDEX_W-1:0] entry_index = '0;
	logic [KEY_W-1:0]   entry_value = '0;
	logic [KEY_W-1:0]   search_key  = '0;
	logic               empty;
	logic               pop         = 1'b0;
	logic [POS_W-1:0]   position;

	// Shadow of the key table and the positions still owed by the block, oldest first
	logic [KEY_W-1:0] key_table [TABLE_DEPTH];
	logic [POS_W-1:0] pending_positions [$];

	int mismatches   = 0;
	int burst_left   = 0;
	int results_seen = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int stall_step   = 0;
	logic [15:0] stall_mask = '1;
	int idle_cycles  = 0;

	sorted_table_lower_bound u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.search_key  (search_key),
		.empty       (empty),
		.pop         (pop),
		.position    (position)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [POS_W-1:0] got,
			input logic [POS_W-1:0] want);
		if (mismatches < REPORT_LINES)
			$display("%0t ns: %s: position %0d, predicted %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Halving walk over the shadow table: the bounds close in on the first entry
	// not below the key, after a check against the last entry.
	function automatic logic [POS_W-1:0] lower_bound_of(input logic [KEY_W-1:0] key);
		int lo;
		int hi;
		int mid;
		if (key > key_table[TABLE_DEPTH-1])
			return POS_NONE;
		lo = 0;
		hi = TABLE_DEPTH - 1;
		while (lo != hi) begin
			mid = (lo + hi) >> 1;
			if (key <= key_table[mid])
				hi = mid;
			else
				lo = mid + 1;
		end
		return POS_W'(lo);
	endfunction

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] random_between(input logic [KEY_W-1:0] lo,
			input logic [KEY_W-1:0] hi);
		logic [KEY_W-1:0] span;
		if (hi <= lo)
			return lo;
		span = hi - lo;
		if (span == KEY_MAX)
			return random_key();
		return lo + random_key() % (span + 1);
	endfunction

	// Offer one request and hold it until taken. Bursts of random length with random
	// gaps between them; a gap of zero joins two bursts into one stretch without idling.
	task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx,
			input logic [KEY_W-1:0] value, input logic [KEY_W-1:0] key,
			input logic known, input logic [POS_W-1:0] known_pos);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 3);
				default:    gap = $urandom_range(4, 24);
			endcase
			burst_left = $urandom_range(1, 48);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push        <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		entry_value <= value;
		search_key  <= key;
		// full as seen here is its value before the edge: low means the request went in
		do @(posedge clk); while (full);
		// Predict in acceptance order; a load only updates the shadow table
		if (op == OP_QUERY)
			pending_positions.insert(pending_positions.size(),
				known ? known_pos : lower_bound_of(key));
		else
			key_table[idx] = value;
	endtask

	// Stimulus
	initial begin
		int slot;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] value;
		logic [KEY_W-1:0] below;
		logic [KEY_W-1:0] above;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Fill every entry in ascending order; keep the last one below all ones
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			value = random_key();
			value[KEY_W-1:KEY_W-INDEX_W] = i[INDEX_W-1:0];
			if (i == TABLE_DEPTH - 1)
				value[0] = 1'b0;
			send_request(OP_LOAD, INDEX_W'(i), value, random_key(), 1'b0, '0);
		end

		// Walk the directed table
		for (int r = 0; r < DIRECTED_ROWS; r++)
			send_request(DIRECTED[r].operation, DIRECTED[r].idx, DIRECTED[r].value,
				DIRECTED[r].key, DIRECTED[r].known, DIRECTED[r].pos);

		// Random part: queries aimed mostly at stored keys and their neighbours, loads
		// mostly kept in order between the neighbours, the rest out of order.
		// Unused fields of each request carry noise.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			case ($urandom_range(0, 7))
				0:       slot = 0;
				1:       slot = TABLE_DEPTH - 1;
				default: slot = $urandom_range(0, TABLE_DEPTH - 1);
			endcase
			if ($urandom_range(0, 99) < 55) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: key = key_table[slot];
					4:          key = key_table[slot] + 1;
					5:          key = key_table[slot] - 1;
					6:          key = $urandom_range(0, 1) ? KEY_MAX : '0;
					default:    key = random_key();
				endcase
				send_request(OP_QUERY, INDEX_W'($urandom), random_key(), key, 1'b0, '0);
			end else begin
				below = (slot == 0) ? '0 : key_table[slot-1];
				above = (slot == TABLE_DEPTH - 1) ? KEY_MAX : key_table[slot+1];
				if ($urandom_range(0, 4) != 0)
					value = random_between(below, above);
				else
					value = random_key();
				send_request(OP_LOAD, INDEX_W'(slot), value, random_key(), 1'b0, '0);
			end
		end
		push <= 1'b0;

		// Drain: wait for every owed position, then give a stray result time to show
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("sorted_table_lower_bound: match");
		else
			$display("sorted_table_lower_bound: mismatch");
		$finish;
	end

	// Compare one taken result with the oldest owed position
	task automatic check_result();
		logic [POS_W-1:0] want;
		if (pending_positions.size() == 0) begin
			report_mismatch("result with no query pending", position, '0);
		end else begin
			want = pending_positions.pop_front();
			if (position !== want)
				report_mismatch("wrong position", position, want);
		end
		results_seen++;
		// Once, hold off the result side long enough for the block to fill and stall
		if (results_seen == HOLD_AFTER && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
	endtask

	// Result side: stall on a 16-bit mask, redrawn each lap as free-running,
	// random, or mostly stalled; drop pop entirely during the hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result();
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (stall_step == 0) begin
					case ($urandom_range(0, 2))
						0:       stall_mask = '1;
						1:       stall_mask = 16'($urandom);
						default: stall_mask = 16'($urandom & $urandom & $urandom);
					endcase
				end
				pop <= stall_mask[stall_step];
				stall_step = (stall_step + 1) % 16;
			end
		end
	end

	// Watchdog: end the run if no request or result moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("sorted_table_lower_bound: mismatch");
				$finish;
			end
		end
	end

endmodule
